/* design/whp_pkg.sv */
// Shared types, constants and the CRC-16/MODBUS byte update for the header parser.
`timescale 1ns / 1ps

package whp_pkg;

  // Header geometry
  localparam int HdrBytes = 24;
  localparam int CapDepth = 23;   // byte 23 is used straight from the input
  localparam logic [4:0] CrcLoPos = 5'd22;
  localparam logic [4:0] LastPos  = 5'd23;

  // CRC-16/MODBUS
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Status codes
  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusTooSmall = 2'd1;
  localparam logic [1:0] StatusInvalid  = 2'd2;
  localparam logic [1:0] StatusCrcFail  = 2'd3;

  // Register indexes
  localparam logic [2:0] RegMagicFirst  = 3'd0;
  localparam logic [2:0] RegMagicSecond = 3'd1;
  localparam logic [2:0] RegWireVersion = 3'd2;
  localparam logic [2:0] RegTypeInvalid = 3'd3;
  localparam logic [2:0] RegTypeLast    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  hdr_length;
    logic [7:0]  pkt_kind;
    logic [7:0]  flags;
    logic [7:0]  ttl;
    logic [7:0]  tclass;
    logic [15:0] src_node;
    logic [15:0] dst_node;
    logic [31:0] conn_tag;
    logic [31:0] seq_num;
    logic [15:0] body_length;
    logic [15:0] header_crc;
  } out_word_t;

  typedef struct packed {
    logic [7:0] magic_first;
    logic [7:0] magic_second;
    logic [7:0] wire_version;
    logic [7:0] type_invalid_code;
    logic [7:0] type_last_code;
  } cfg_t;

  // One byte of reflected CRC update, eight shift steps
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

/* design/whp_cfg_regs.sv */
// Configuration register file of the header parser.
`timescale 1ns / 1ps

module whp_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output whp_pkg::cfg_t     cfg
);

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic_first       <= 8'd0;
      cfg.magic_second      <= 8'd0;
      cfg.wire_version      <= 8'd1;
      cfg.type_invalid_code <= 8'd0;
      cfg.type_last_code    <= 8'd255;
    end else if (cfg_write) begin
      unique case (cfg_index)
        whp_pkg::RegMagicFirst:  cfg.magic_first       <= cfg_data;
        whp_pkg::RegMagicSecond: cfg.magic_second      <= cfg_data;
        whp_pkg::RegWireVersion: cfg.wire_version      <= cfg_data;
        whp_pkg::RegTypeInvalid: cfg.type_invalid_code <= cfg_data;
        whp_pkg::RegTypeLast:    cfg.type_last_code    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* design/whp_deframer.sv */
// Header capture, running CRC, frame tracking and result decode.
`timescale 1ns / 1ps

module whp_deframer (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  whp_pkg::in_word_t   in_word,
  input  whp_pkg::cfg_t       cfg,
  output logic                res_fire,
  output whp_pkg::out_word_t  res_word
);

  logic [4:0]  pos;
  logic [15:0] crc;
  logic        swallowing;
  logic [7:0]  cap [0:whp_pkg::CapDepth-1];

  logic [7:0]  crc_feed;
  logic [15:0] crc_next;
  logic [15:0] rx_crc;
  logic [15:0] src;
  logic [15:0] dst;
  logic        magic_bad;
  logic        fields_bad;

  // CRC update and field decode for the current word
  always_comb begin
    crc_feed = (pos >= whp_pkg::CrcLoPos) ? 8'h00 : in_word.data_byte;
    crc_next = whp_pkg::crc16_byte(crc, crc_feed);
    rx_crc   = {in_word.data_byte, cap[whp_pkg::CrcLoPos]};
    src      = {cap[9], cap[8]};
    dst      = {cap[11], cap[10]};
    magic_bad = (cap[0] != cfg.magic_first) || (cap[1] != cfg.magic_second);
    fields_bad = (cap[2] != cfg.wire_version) ||
                 (cap[3] < 8'(whp_pkg::HdrBytes)) ||
                 !((cap[4] > cfg.type_invalid_code) && (cap[4] <= cfg.type_last_code)) ||
                 (src == 16'd0) || (dst == 16'd0);
  end

  // Result word
  always_comb begin
    res_fire = 1'b0;
    res_word = '0;
    if (step && !swallowing) begin
      if (pos == whp_pkg::LastPos) begin
        res_fire = 1'b1;
        if (magic_bad) begin
          res_word.status = whp_pkg::StatusInvalid;
        end else if (crc_next != rx_crc) begin
          res_word.status = whp_pkg::StatusCrcFail;
        end else begin
          res_word.status      = fields_bad ? whp_pkg::StatusInvalid : whp_pkg::StatusOk;
          res_word.hdr_length  = cap[3];
          res_word.pkt_kind    = cap[4];
          res_word.flags       = cap[5];
          res_word.ttl         = cap[6];
          res_word.tclass      = cap[7];
          res_word.src_node    = src;
          res_word.dst_node    = dst;
          res_word.conn_tag    = {cap[15], cap[14], cap[13], cap[12]};
          res_word.seq_num     = {cap[19], cap[18], cap[17], cap[16]};
          res_word.body_length = {cap[21], cap[20]};
          res_word.header_crc  = rx_crc;
        end
      end else if (in_word.last_byte) begin
        res_fire = 1'b1;
        res_word.status = whp_pkg::StatusTooSmall;
      end
    end
  end

  // Frame position, CRC and trailer swallow state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos        <= 5'd0;
      crc        <= whp_pkg::CrcInit;
      swallowing <= 1'b0;
    end else if (step) begin
      if (swallowing) begin
        if (in_word.last_byte) begin
          swallowing <= 1'b0;
          pos        <= 5'd0;
          crc        <= whp_pkg::CrcInit;
        end
      end else if (pos == whp_pkg::LastPos) begin
        pos        <= 5'd0;
        crc        <= whp_pkg::CrcInit;
        swallowing <= !in_word.last_byte;
      end else if (in_word.last_byte) begin
        pos <= 5'd0;
        crc <= whp_pkg::CrcInit;
      end else begin
        pos <= pos + 5'd1;
        crc <= crc_next;
      end
    end
  end

  // Header byte capture, no reset
  always_ff @(posedge clk) begin
    if (step && !swallowing) begin
      for (int i = 0; i < whp_pkg::CapDepth; i++) begin
        if (pos == 5'(i)) begin
          cap[i] <= in_word.data_byte;
        end
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= whp_pkg::LastPos)
    else $error("byte position past end of header");

  a_swallow_idle: assert property (@(posedge clk) disable iff (rst)
    swallowing |-> (pos == 5'd0) && (crc == whp_pkg::CrcInit))
    else $error("frame state not restarted while swallowing");

  a_frame_start_crc: assert property (@(posedge clk) disable iff (rst)
    (pos == 5'd0) |-> (crc == whp_pkg::CrcInit))
    else $error("CRC not at initial value at frame start");

  a_enter_swallow: assert property (@(posedge clk) disable iff (rst)
    (step && !swallowing && (pos == whp_pkg::LastPos) && !in_word.last_byte)
      |=> swallowing)
    else $error("trailing bytes not swallowed");

  a_no_result_swallow: assert property (@(posedge clk) disable iff (rst)
    swallowing |-> !res_fire)
    else $error("result emitted while swallowing");

endmodule

/* design/wire_header_parser_crc16_core.sv */
// Top level of the byte-serial wire header parser with CRC-16/MODBUS check.
//
// Usage:
//   Input channel (byte_valid / byte_stall / byte_word) carries one frame byte
//   per word with a last-byte mark. Output channel (result_valid /
//   result_stall / result_word) carries one result per 24-byte header, or one
//   too-small result when a frame ends early. Trailing bytes after a header
//   give no word, up to and including the byte marked last.
//   Configuration is a plain write port (cfg_write, cfg_index, cfg_data),
//   written only while no frame is in progress; the block leaves that to the user.
// Timing:
//   One byte per cycle sustained while result_stall is low. A byte is held
//   in the input register, and the CRC byte update and field decode run
//   from it into the result register.
//   The CRC update of the byte just taken sets that rate.
// Reset (rst, synchronous): clears both channel registers, frame position,
//   CRC and swallow state, and loads register defaults.
// Stall: while result_stall holds a result, the input register fills and
//   byte_stall rises; nothing is dropped.
`timescale 1ns / 1ps

module wire_header_parser_crc16_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_stall,
  input  whp_pkg::in_word_t   byte_word,
  output logic                result_valid,
  input  logic                result_stall,
  output whp_pkg::out_word_t  result_word,
  input  logic                cfg_write,
  input  logic [2:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  logic               hold_valid;
  whp_pkg::in_word_t  hold_word;
  logic               step;
  logic               accept;
  logic               res_fire;
  whp_pkg::out_word_t res_word;
  whp_pkg::cfg_t      cfg;

  // Handshake: process the held word when the result register can take it
  assign step       = hold_valid && (!result_valid || !result_stall);
  assign byte_stall = hold_valid && !step;
  assign accept     = byte_valid && !byte_stall;

  whp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  whp_deframer u_deframer (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_word  (hold_word),
    .cfg      (cfg),
    .res_fire (res_fire),
    .res_word (res_word)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (step) begin
      hold_valid <= 1'b0;
    end
    if (accept) begin
      hold_word <= byte_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && res_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (step && res_fire) begin
      result_word <= res_word;
    end
  end

endmodule

/* verif/tb_top.sv */
// Testbench for the byte-serial wire header parser: frames in, decoded header words out.
`timescale 1ns / 1ps

module tb_top;

  localparam int CycleLimit   = 200000;
  localparam int SettleCycles = 6;
  localparam int ByteGoal     = 1380;
  localparam int PhaseCount   = 6;

  // Frame shapes the stimulus can build
  typedef enum logic [3:0] {
    HdrGood, HdrBadMagic0, HdrBadMagic1, HdrBadCrc, HdrBadVersion, HdrShortLen,
    HdrTypeLow, HdrTypeHigh, HdrSrcZero, HdrDstZero, HdrEarlyEnd, HdrNoise
  } frame_kind_e;

  typedef enum logic [1:0] {FillRandom, FillZero, FillOnes} fill_e;

  // One directed frame; status is typed in only where it is obvious
  typedef struct packed {
    frame_kind_e kind;
    fill_e       fill;
    logic [5:0]  cut;
    logic [5:0]  trail;
    logic        typed;
    logic [1:0]  status;
  } probe_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               byte_valid = 1'b0;
  logic               byte_stall;
  whp_pkg::in_word_t  byte_word = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  whp_pkg::out_word_t result_word;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [7:0]         cfg_data = '0;

  // Predictor state and its copy of the registers
  whp_pkg::cfg_t live_cfg;
  int            hdr_pos;
  logic [15:0]   crc_acc;
  logic [7:0]    hdr_bytes [24];
  bit            draining;

  whp_pkg::out_word_t pending_headers [$];
  bit                 typed_armed;
  whp_pkg::out_word_t typed_word;
  int                 bytes_sent;
  int                 mismatch_count;
  int                 cycle_count;
  int                 rx_wait;
  bit                 rx_burst;

  probe_row_t probe_table [15] = '{
    {HdrEarlyEnd,   FillRandom, 6'd1,  6'd0, 1'b1, whp_pkg::StatusTooSmall},
    {HdrEarlyEnd,   FillRandom, 6'd23, 6'd0, 1'b1, whp_pkg::StatusTooSmall},
    {HdrGood,       FillZero,   6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrGood,       FillOnes,   6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrGood,       FillRandom, 6'd0,  6'd3, 1'b0, whp_pkg::StatusOk},
    {HdrBadMagic0,  FillRandom, 6'd0,  6'd0, 1'b1, whp_pkg::StatusInvalid},
    {HdrBadMagic1,  FillOnes,   6'd0,  6'd0, 1'b1, whp_pkg::StatusInvalid},
    {HdrBadCrc,     FillRandom, 6'd0,  6'd0, 1'b1, whp_pkg::StatusCrcFail},
    {HdrBadVersion, FillRandom, 6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrShortLen,   FillRandom, 6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrTypeLow,    FillRandom, 6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrSrcZero,    FillRandom, 6'd0,  6'd1, 1'b0, whp_pkg::StatusOk},
    {HdrDstZero,    FillRandom, 6'd0,  6'd0, 1'b0, whp_pkg::StatusOk},
    {HdrNoise,      FillRandom, 6'd0,  6'd1, 1'b0, whp_pkg::StatusOk},
    {HdrGood,       FillRandom, 6'd0,  6'd0, 1'b0, whp_pkg::StatusOk}
  };

  wire_header_parser_crc16_core u_top (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .byte_word    (byte_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_word  (result_word),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bit-serial CRC-16/MODBUS: feed data bits LSB first against the register LSB
  function automatic logic [15:0] crc_mix(input logic [15:0] acc, input logic [7:0] d);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      r = {1'b0, r[15:1]} ^ ((r[0] ^ d[k]) ? whp_pkg::CrcPoly : 16'h0000);
    end
    return r;
  endfunction

  // Advance the predictor by one accepted byte; returns 1 when a header word is due
  function automatic bit deframe_byte(input whp_pkg::in_word_t w,
                                      output whp_pkg::out_word_t res);
    logic [15:0] src;
    logic [15:0] dst;
    bit          bad;
    res = '0;
    if (draining) begin
      if (w.last_byte) begin
        draining = 1'b0;
        hdr_pos  = 0;
        crc_acc  = whp_pkg::CrcInit;
      end
      return 1'b0;
    end
    hdr_bytes[hdr_pos] = w.data_byte;
    // CRC bytes enter the running sum as zero
    crc_acc = crc_mix(crc_acc, (hdr_pos >= whp_pkg::CrcLoPos) ? 8'h00 : w.data_byte);
    hdr_pos++;
    if (hdr_pos < whp_pkg::HdrBytes) begin
      if (!w.last_byte) return 1'b0;
      res.status = whp_pkg::StatusTooSmall;
      hdr_pos    = 0;
      crc_acc    = whp_pkg::CrcInit;
      return 1'b1;
    end
    if (hdr_bytes[0] != live_cfg.magic_first || hdr_bytes[1] != live_cfg.magic_second) begin
      res.status = whp_pkg::StatusInvalid;
    end else if (crc_acc != {hdr_bytes[23], hdr_bytes[22]}) begin
      res.status = whp_pkg::StatusCrcFail;
    end else begin
      src = {hdr_bytes[9], hdr_bytes[8]};
      dst = {hdr_bytes[11], hdr_bytes[10]};
      bad = hdr_bytes[2] != live_cfg.wire_version || hdr_bytes[3] < whp_pkg::HdrBytes ||
            !(hdr_bytes[4] > live_cfg.type_invalid_code &&
              hdr_bytes[4] <= live_cfg.type_last_code) ||
            src == 16'h0000 || dst == 16'h0000;
      res.status      = bad ? whp_pkg::StatusInvalid : whp_pkg::StatusOk;
      res.hdr_length  = hdr_bytes[3];
      res.pkt_kind    = hdr_bytes[4];
      res.flags       = hdr_bytes[5];
      res.ttl         = hdr_bytes[6];
      res.tclass      = hdr_bytes[7];
      res.src_node    = src;
      res.dst_node    = dst;
      res.conn_tag    = {hdr_bytes[15], hdr_bytes[14], hdr_bytes[13], hdr_bytes[12]};
      res.seq_num     = {hdr_bytes[19], hdr_bytes[18], hdr_bytes[17], hdr_bytes[16]};
      res.body_length = {hdr_bytes[21], hdr_bytes[20]};
      res.header_crc  = {hdr_bytes[23], hdr_bytes[22]};
    end
    hdr_pos  = 0;
    crc_acc  = whp_pkg::CrcInit;
    draining = !w.last_byte;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) flag_mismatch($sformatf("%s got 0x%0h exp 0x%0h", name, got, want));
  endtask

  task automatic check_result(input whp_pkg::out_word_t got);
    whp_pkg::out_word_t want;
    if (pending_headers.size() == 0) begin
      flag_mismatch($sformatf("result word with none outstanding, status %0d", got.status));
      return;
    end
    want = pending_headers.pop_front();
    compare_field("status",      got.status,      want.status);
    compare_field("hdr_length",  got.hdr_length,  want.hdr_length);
    compare_field("pkt_kind",    got.pkt_kind,    want.pkt_kind);
    compare_field("flags",       got.flags,       want.flags);
    compare_field("ttl",         got.ttl,         want.ttl);
    compare_field("tclass",      got.tclass,      want.tclass);
    compare_field("src_node",    got.src_node,    want.src_node);
    compare_field("dst_node",    got.dst_node,    want.dst_node);
    compare_field("conn_tag",    got.conn_tag,    want.conn_tag);
    compare_field("seq_num",     got.seq_num,     want.seq_num);
    compare_field("body_length", got.body_length, want.body_length);
    compare_field("header_crc",  got.header_crc,  want.header_crc);
  endtask

  // Result side: take words, hold stall for a drawn number of cycles per word
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      rx_wait = 0;
      rx_burst = 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(result_word);
        if ($urandom_range(19, 0) == 0) rx_burst = !rx_burst;
        rx_wait = rx_burst ? 0 : $urandom_range(8, 0);
      end else if (result_valid && rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      result_stall <= (rx_wait != 0);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one byte after a drawn gap; the predictor runs at the accepting edge
  task automatic push_byte(input whp_pkg::in_word_t w, input bit burst);
    whp_pkg::out_word_t res;
    int                 gap;
    gap = burst ? 0 : $urandom_range(8, 0);
    repeat (gap) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_word  <= w;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    if (deframe_byte(w, res)) begin
      if (typed_armed) begin
        pending_headers.push_back(typed_word);
        typed_armed = 1'b0;
      end else begin
        pending_headers.push_back(res);
      end
    end
  endtask

  // Idle the input until every header word is back and the pipeline is empty
  task automatic settle();
    byte_valid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Build one frame against the live registers and send it, ending on a last byte
  task automatic play_frame(input frame_kind_e kind, input fill_e fill, input int cut,
                            input int trail);
    logic [7:0]        h [24];
    logic [15:0]       sum;
    whp_pkg::in_word_t w;
    bit                burst;
    int                span;
    int                flip_at;
    burst = ($urandom_range(3, 0) == 0);
    for (int i = 0; i < 24; i++) h[i] = 8'($urandom);
    if (kind != HdrNoise) begin
      for (int i = 5; i < 22; i++) begin
        if (fill == FillZero) h[i] = 8'h00;
        if (fill == FillOnes) h[i] = 8'hFF;
      end
      h[0] = live_cfg.magic_first;
      h[1] = live_cfg.magic_second;
      h[2] = live_cfg.wire_version;
      case (fill)
        FillZero: h[3] = 8'(whp_pkg::HdrBytes);
        FillOnes: h[3] = 8'hFF;
        default:  h[3] = 8'($urandom_range(255, whp_pkg::HdrBytes));
      endcase
      if (live_cfg.type_invalid_code < live_cfg.type_last_code) begin
        case (fill)
          FillZero: h[4] = live_cfg.type_invalid_code + 8'd1;
          FillOnes: h[4] = live_cfg.type_last_code;
          default:  h[4] = 8'($urandom_range(live_cfg.type_last_code,
                                             live_cfg.type_invalid_code + 1));
        endcase
      end
      if ({h[9], h[8]} == 16'h0000) h[8] = 8'h01;
      if ({h[11], h[10]} == 16'h0000) h[10] = 8'h01;
      // One fault per frame
      case (kind)
        HdrBadMagic0:  h[0] ^= 8'($urandom_range(255, 1));
        HdrBadMagic1:  h[1] ^= 8'($urandom_range(255, 1));
        HdrBadVersion: h[2] ^= 8'($urandom_range(255, 1));
        HdrShortLen:   h[3] = 8'($urandom_range(whp_pkg::HdrBytes - 1, 0));
        HdrTypeLow:    h[4] = 8'($urandom_range(live_cfg.type_invalid_code, 0));
        HdrTypeHigh: begin
          if (live_cfg.type_last_code != 8'hFF)
            h[4] = 8'($urandom_range(255, live_cfg.type_last_code + 1));
        end
        HdrSrcZero: begin
          h[8] = 8'h00;
          h[9] = 8'h00;
        end
        HdrDstZero: begin
          h[10] = 8'h00;
          h[11] = 8'h00;
        end
        default: ;
      endcase
      sum = whp_pkg::CrcInit;
      for (int i = 0; i < 22; i++) sum = crc_mix(sum, h[i]);
      sum = crc_mix(sum, 8'h00);
      sum = crc_mix(sum, 8'h00);
      h[22] = sum[7:0];
      h[23] = sum[15:8];
      if (kind == HdrBadCrc) begin
        flip_at = 22 + $urandom_range(1, 0);
        h[flip_at] ^= 8'($urandom_range(255, 1));
      end
    end
    span = (kind == HdrEarlyEnd) ? cut : whp_pkg::HdrBytes;
    for (int i = 0; i < span; i++) begin
      w.data_byte = h[i];
      w.last_byte = (kind == HdrEarlyEnd) ? (i == cut - 1) :
                                            (i == whp_pkg::LastPos && trail == 0);
      push_byte(w, burst);
    end
    // Trailing bytes after a full header are swallowed up to the last mark
    for (int t = 0; t < trail; t++) begin
      w.data_byte = 8'($urandom);
      w.last_byte = (t == trail - 1);
      push_byte(w, burst);
    end
  endtask

  // Register writes land only while the parser is idle
  task automatic program_regs(input whp_pkg::cfg_t c, input bit poke_unused);
    logic [7:0] v;
    int         top_idx;
    settle();
    top_idx = poke_unused ? 7 : int'(whp_pkg::RegTypeLast);
    for (int i = whp_pkg::RegMagicFirst; i <= top_idx; i++) begin
      case (i[2:0])
        whp_pkg::RegMagicFirst: begin
          v = c.magic_first;
          live_cfg.magic_first = v;
        end
        whp_pkg::RegMagicSecond: begin
          v = c.magic_second;
          live_cfg.magic_second = v;
        end
        whp_pkg::RegWireVersion: begin
          v = c.wire_version;
          live_cfg.wire_version = v;
        end
        whp_pkg::RegTypeInvalid: begin
          v = c.type_invalid_code;
          live_cfg.type_invalid_code = v;
        end
        whp_pkg::RegTypeLast: begin
          v = c.type_last_code;
          live_cfg.type_last_code = v;
        end
        default: v = 8'($urandom);  // unmapped index, ignored by the block
      endcase
      cfg_write <= 1'b1;
      cfg_index <= i[2:0];
      cfg_data  <= v;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    whp_pkg::cfg_t c;
    frame_kind_e   kind;
    fill_e         fill;
    int            pick;
    int            trail;
    int            goal;
    live_cfg       = {8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
    hdr_pos        = 0;
    crc_acc        = whp_pkg::CrcInit;
    draining       = 1'b0;
    typed_armed    = 1'b0;
    typed_word     = '0;
    bytes_sent     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    for (int i = 0; i < 24; i++) hdr_bytes[i] = 8'h00;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values
    foreach (probe_table[r]) begin
      if (probe_table[r].typed) begin
        typed_word        = '0;
        typed_word.status = probe_table[r].status;
        typed_armed       = 1'b1;
      end
      play_frame(probe_table[r].kind, probe_table[r].fill, probe_table[r].cut,
                 probe_table[r].trail);
    end

    // Random frames, one register setting per phase
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: c = {8'h00, 8'h00, 8'h01, 8'h00, 8'hFF};
        1: c = {8'hFF, 8'hFF, 8'hFF, 8'hFE, 8'hFF};
        2: c = {8'h00, 8'hFF, 8'h00, 8'h00, 8'h01};
        3: c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        4: c = {8'hA5, 8'h5A, 8'h02, 8'hFF, 8'hFF};  // empty type range
        default: begin
          c = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(127, 0)),
               8'($urandom_range(255, 128))};
        end
      endcase
      program_regs(c, p == 0);
      goal = bytes_sent + ByteGoal / PhaseCount;
      while (bytes_sent < goal) begin
        pick = $urandom_range(99, 0);
        if (pick < 55) kind = HdrGood;
        else if (pick < 80) kind = frame_kind_e'($urandom_range(HdrDstZero, HdrBadMagic0));
        else if (pick < 92) kind = HdrEarlyEnd;
        else kind = HdrNoise;
        pick = $urandom_range(9, 0);
        fill = (pick == 0) ? FillZero : (pick == 1) ? FillOnes : FillRandom;
        pick = $urandom_range(9, 0);
        trail = (pick < 6) ? 0 : (pick < 9) ? $urandom_range(4, 1) : $urandom_range(40, 5);
        if ($urandom_range(24, 0) == 0) settle();
        play_frame(kind, fill, $urandom_range(whp_pkg::HdrBytes - 1, 1), trail);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
